// ----- src/doy_pkg.sv -----
// shared constants, tables and helper functions for the day-of-year date converter
package doy_pkg;

	// field widths
	localparam int DayW    = 5;
	localparam int MonthW  = 4;
	localparam int YearW   = 14;
	localparam int OffsW   = 16;
	localparam int DoyW    = 9;
	localparam int OutYearW = 15;
	localparam int InDataW = 40;
	localparam int OutDataW = 40;

	// shared adder width, covers the signed offset plus one month length
	localparam int AluW = 17;
	// year residue modulo the 400 year cycle
	localparam int ResW = 9;

	localparam int unsigned CycleYears = 400;

	// action codes
	localparam logic ACT_TO_DOY  = 1'b0;
	localparam logic ACT_TO_DATE = 1'b1;

	// month indexes, zero based
	localparam logic [MonthW-1:0] MON_JAN = 4'd0;
	localparam logic [MonthW-1:0] MON_FEB = 4'd1;
	localparam logic [MonthW-1:0] MON_DEC = 4'd11;

	// leap rule from the residue of the year modulo 400
	function automatic logic is_leap(input logic [ResW-1:0] r);
		logic century;
		begin
			century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
			is_leap = (r[1:0] == 2'b00) && !century;
		end
	endfunction

	// length of a zero based month
	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
		begin
			case (m)
				4'd0:    month_len = 5'd31;
				4'd1:    month_len = leap ? 5'd29 : 5'd28;
				4'd2:    month_len = 5'd31;
				4'd3:    month_len = 5'd30;
				4'd4:    month_len = 5'd31;
				4'd5:    month_len = 5'd30;
				4'd6:    month_len = 5'd31;
				4'd7:    month_len = 5'd31;
				4'd8:    month_len = 5'd30;
				4'd9:    month_len = 5'd31;
				4'd10:   month_len = 5'd30;
				4'd11:   month_len = 5'd31;
				default: month_len = 5'd31;
			endcase
		end
	endfunction

	// days in the first n months of a common year
	function automatic logic [DoyW-1:0] cum_days(input logic [MonthW-1:0] n);
		begin
			case (n)
				4'd0:    cum_days = 9'd0;
				4'd1:    cum_days = 9'd31;
				4'd2:    cum_days = 9'd59;
				4'd3:    cum_days = 9'd90;
				4'd4:    cum_days = 9'd120;
				4'd5:    cum_days = 9'd151;
				4'd6:    cum_days = 9'd181;
				4'd7:    cum_days = 9'd212;
				4'd8:    cum_days = 9'd243;
				4'd9:    cum_days = 9'd273;
				4'd10:   cum_days = 9'd304;
				4'd11:   cum_days = 9'd334;
				default: cum_days = 9'd365;
			endcase
		end
	endfunction

endpackage

// ----- src/doy_alu.sv -----
// shared add/subtract unit used by the year reduction and month walk steps of the sequencer
module doy_alu
	import doy_pkg::*;
(
	input  logic signed [AluW-1:0] a,
	input  logic signed [AluW-1:0] b,
	input  logic                   sub,
	output logic signed [AluW-1:0] res,
	output logic                   neg,
	output logic                   zero
);

	// one adder, operand b inverted for subtraction
	always_comb begin
		res  = sub ? (a - b) : (a + b);
		neg  = res[AluW-1];
		zero = (res == '0);
	end

endmodule

// ----- src/day_of_year_date_converter.sv -----
// top level of the gregorian day-of-year / date converter
//
// usage:
//  - one input transaction on s_tvalid/s_tready carries one request; s_tuser
//    selects the action (0: date to day of year, 1: day offset to date)
//  - one result transaction per request comes out on m_tvalid/m_tready
//  - a request first reduces its year modulo 400 with a shared subtractor,
//    one subtraction of 400 per cycle
//  - action 0 then takes its result from a table of month offsets
//  - action 1 walks month by month through the same subtractor, one month per
//    cycle; an offset of magnitude 32768 spans about 1080 months
//  - s_tready is high only while the sequencer is idle; one request is
//    handled at a time
//  - the result waits in an output register; a new request may be accepted
//    while it waits, and a finished result holds in the sequencer until the
//    output register is free, so a stalled receiver stalls the block
//  - arst_n clears the sequencer and the output valid; no state survives
//    between requests
module day_of_year_date_converter
	import doy_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// day[4:0], month[8:5], year[22:9], day_offset[38:23], zero fill above
	input  logic [InDataW-1:0]  s_tdata,
	// action[0]
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// day_of_year[8:0], out_day[13:9], out_month[17:14], out_year[32:18], zero fill above
	output logic [OutDataW-1:0] m_tdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;

	// request fields
	logic                    action_q;
	logic [DayW-1:0]         day_q;
	logic [MonthW-1:0]       month_q;
	logic [YearW-1:0]        year_q;
	logic signed [OffsW-1:0] offs_q;

	// working registers
	logic [YearW-1:0]           r_q;
	logic signed [OutYearW-1:0] y_q;
	logic signed [AluW-1:0]     rem_q;
	logic [MonthW-1:0]          m_q;
	logic                       fwd_q;

	// staged result
	logic [DoyW-1:0] res_doy_q;
	logic [DayW-1:0] res_day_q;

	// output register
	logic                 out_valid_q;
	logic [OutDataW-1:0]  out_data_q;

	// shared unit
	logic signed [AluW-1:0] alu_a;
	logic signed [AluW-1:0] alu_b;
	logic                   alu_sub;
	logic signed [AluW-1:0] alu_res;
	logic                   alu_neg;
	logic                   alu_zero;

	logic                   leap;
	logic [DayW-1:0]        cur_len;
	logic [MonthW-1:0]      prior_months;
	logic [DoyW-1:0]        doy_sum;
	logic [ResW-1:0]        r_res;
	logic [ResW-1:0]        r_inc;
	logic [ResW-1:0]        r_dec;
	logic                   out_free;

	doy_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.sub  (alu_sub),
		.res  (alu_res),
		.neg  (alu_neg),
		.zero (alu_zero)
	);

	// leap flag and month length of the current walk position
	always_comb begin
		r_res   = r_q[ResW-1:0];
		leap    = is_leap(r_res);
		cur_len = month_len(m_q, leap);
		r_inc   = (r_res == ResW'(CycleYears - 1)) ? '0 : r_res + 9'd1;
		r_dec   = (r_res == '0) ? ResW'(CycleYears - 1) : r_res - 9'd1;
	end

	// operand selection for the shared unit
	always_comb begin
		if (state_q == ST_MOD) begin
			alu_a   = AluW'(signed'({1'b0, r_q}));
			alu_b   = AluW'(signed'(CycleYears));
			alu_sub = 1'b1;
		end else begin
			alu_a   = rem_q;
			alu_b   = AluW'(signed'({1'b0, cur_len}));
			alu_sub = fwd_q;
		end
	end

	// day of year from the month offset table
	always_comb begin
		if (month_q == 4'd0) begin
			prior_months = 4'd0;
		end else if (month_q > 4'd13) begin
			prior_months = 4'd12;
		end else begin
			prior_months = month_q - 4'd1;
		end
		doy_sum = DoyW'(day_q) + cum_days(prior_months)
			+ DoyW'((leap && (prior_months >= 4'd2)) ? 1'b1 : 1'b0);
	end

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (alu_neg) state_q <= (action_q == ACT_TO_DOY) ? ST_DONE : ST_WALK;
				end
				ST_WALK: begin
					if (fwd_q ? (alu_neg || alu_zero) : !(alu_neg || alu_zero)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					action_q <= s_tuser;
					day_q    <= s_tdata[4:0];
					month_q  <= s_tdata[8:5];
					year_q   <= s_tdata[22:9];
					offs_q   <= s_tdata[38:23];
					r_q      <= s_tdata[22:9];
				end
			end
			ST_MOD: begin
				if (!alu_neg) begin
					r_q <= alu_res[YearW-1:0];
				end else if (action_q == ACT_TO_DOY) begin
					res_doy_q <= doy_sum;
					res_day_q <= '0;
				end else if (!offs_q[OffsW-1] && (offs_q != '0)) begin
					// positive offset walks forward from january
					fwd_q <= 1'b1;
					y_q   <= signed'({1'b0, year_q});
					m_q   <= MON_JAN;
					rem_q <= AluW'(offs_q);
				end else begin
					// zero or negative offset walks back from december of the year before
					fwd_q <= 1'b0;
					y_q   <= signed'({1'b0, year_q}) - 15'sd1;
					r_q   <= YearW'(r_dec);
					m_q   <= MON_DEC;
					rem_q <= AluW'(offs_q);
				end
			end
			ST_WALK: begin
				if (fwd_q) begin
					if (!alu_neg && !alu_zero) begin
						rem_q <= alu_res;
						if (m_q == MON_DEC) begin
							m_q <= MON_JAN;
							y_q <= y_q + 15'sd1;
							r_q <= YearW'(r_inc);
						end else begin
							m_q <= m_q + 4'd1;
						end
					end else begin
						res_day_q <= rem_q[DayW-1:0];
						res_doy_q <= '0;
					end
				end else begin
					if (alu_neg || alu_zero) begin
						rem_q <= alu_res;
						if (m_q == MON_JAN) begin
							m_q <= MON_DEC;
							y_q <= y_q - 15'sd1;
							r_q <= YearW'(r_dec);
						end else begin
							m_q <= m_q - 4'd1;
						end
					end else begin
						res_day_q <= alu_res[DayW-1:0];
						res_doy_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			if (action_q == ACT_TO_DOY) begin
				out_data_q <= OutDataW'(res_doy_q);
			end else begin
				out_data_q <= {7'd0, y_q, m_q + 4'd1, res_day_q, 9'd0};
			end
		end
	end

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the day-of-year / date converter
module tb;
	import doy_pkg::*;

	// result fields as the block packs them, lowest bits last
	typedef struct packed {
		logic signed [OutYearW-1:0] year;
		logic [MonthW-1:0]          month;
		logic [DayW-1:0]            day;
		logic [DoyW-1:0]            doy;
	} date_result_t;

	// calendar predictor plus queue of pending results
	class date_scoreboard;
		date_result_t due_results[$];
		int errors;
		int common_month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

		// non-negative remainder, so negative years follow the same cycle
		function int pmod(int a, int m);
			int r;
			r = a % m;
			return (r < 0) ? r + m : r;
		endfunction

		function bit leap_year(int y);
			if (pmod(y, 4) != 0)
				return 1'b0;
			if (pmod(y, 100) != 0)
				return 1'b1;
			return pmod(y, CycleYears) == 0;
		endfunction

		function int month_days(int m, bit lp);
			if (m == int'(MON_FEB) && lp)
				return 29;
			return common_month_days[m];
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// work out the result of one accepted request
		function void note_request(logic act, logic [InDataW-1:0] data);
			int d, mo, y, rem, m, sum, lim;
			bit lp;
			date_result_t r;
			d   = int'(data[4:0]);
			mo  = int'(data[8:5]);
			y   = int'(data[22:9]);
			rem = int'($signed(data[38:23]));
			r   = '0;
			if (act == ACT_TO_DOY) begin
				// day plus all earlier months, months past december add the whole year
				lp  = leap_year(y);
				lim = mo - 1;
				if (lim > 12)
					lim = 12;
				sum = d;
				for (m = 0; m < lim; m++)
					sum += month_days(m, lp);
				r.doy = DoyW'(sum);
			end else if (rem > 0) begin
				// forward walk from january of the reference year
				m  = int'(MON_JAN);
				lp = leap_year(y);
				while (rem > month_days(m, lp)) begin
					rem -= month_days(m, lp);
					m++;
					if (m > int'(MON_DEC)) begin
						m  = int'(MON_JAN);
						y++;
						lp = leap_year(y);
					end
				end
				r.day   = DayW'(rem);
				r.month = MonthW'(m + 1);
				r.year  = OutYearW'(y);
			end else begin
				// backward walk from december 31 of the previous year
				m  = int'(MON_DEC);
				y  = y - 1;
				lp = leap_year(y);
				while (-rem >= month_days(m, lp)) begin
					rem += month_days(m, lp);
					m--;
					if (m < int'(MON_JAN)) begin
						m  = int'(MON_DEC);
						y--;
						lp = leap_year(y);
					end
				end
				r.day   = DayW'(month_days(m, lp) + rem);
				r.month = MonthW'(m + 1);
				r.year  = OutYearW'(y);
			end
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
			end
		endfunction

		// compare one accepted result against the oldest prediction
		function void check_result(logic [OutDataW-1:0] data);
			date_result_t got, want;
			got = data[$bits(date_result_t)-1:0];
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $realtime, data);
				return;
			end
			want = due_results.pop_front();
			compare_field("day_of_year", int'(want.doy), int'(got.doy));
			compare_field("out_day", int'(want.day), int'(got.day));
			compare_field("out_month", int'(want.month), int'(got.month));
			compare_field("out_year", int'(want.year), int'(got.year));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// day[4:0], month[8:5], year[22:9], day_offset[38:23], zero fill above
	logic [InDataW-1:0]  s_tdata;
	// action[0]
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	// day_of_year[8:0], out_day[13:9], out_month[17:14], out_year[32:18], zero fill above
	logic [OutDataW-1:0] m_tdata;

	date_scoreboard sb = new();
	int results_seen;
	bit quiet;

	day_of_year_date_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// offer one request, optionally after a short idle burst, until accepted
	task automatic send_request(input logic act, input logic [DayW-1:0] d,
			input logic [MonthW-1:0] mo, input logic [YearW-1:0] y,
			input logic [OffsW-1:0] offs);
		logic [InDataW-1:0] data;
		data = {1'b0, offs, y, mo, d};
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		sb.note_request(act, data);
	endtask

	// random request, mostly well-formed dates and moderate offsets
	task automatic send_random();
		logic [DayW-1:0]   d;
		logic [MonthW-1:0] mo;
		logic [YearW-1:0]  y;
		logic [OffsW-1:0]  offs;
		int pick;
		d    = DayW'($urandom_range(1, 31));
		mo   = MonthW'($urandom_range(1, 12));
		y    = YearW'($urandom_range(1, 9999));
		pick = int'($urandom_range(0, 99));
		if (pick < 55)
			offs = OffsW'($urandom_range(0, 1600) - 800);
		else if (pick < 75)
			offs = OffsW'($urandom);
		else if (pick < 85)
			offs = OffsW'($urandom_range(0, 2) - 1);
		else begin
			// noise over the full field ranges
			d    = DayW'($urandom);
			mo   = MonthW'($urandom);
			y    = YearW'($urandom);
			offs = OffsW'($urandom);
		end
		send_request($urandom_range(0, 1) ? ACT_TO_DATE : ACT_TO_DOY, d, mo, y, offs);
	endtask

	// result side monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
			results_seen++;
		end
	end

	// receiver: random stalls, one long hold-off to back the block up
	initial begin : receiver
		bit held;
		held = 1'b0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= 40) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// run limit
	initial begin
		#8000000;
		$display("tb: errors");
		$finish;
	end

	// reset, directed requests, random requests, drain
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= ACT_TO_DOY;
		s_tdata  <= '0;
		quiet = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// date to day of year: bounds, leap and century years, odd months
		send_request(ACT_TO_DOY, 5'd1, 4'd1, 14'd1, 16'h0000);
		send_request(ACT_TO_DOY, 5'd31, 4'd12, 14'd2000, 16'h0000);
		send_request(ACT_TO_DOY, 5'd31, 4'd12, 14'd1900, 16'h0000);
		send_request(ACT_TO_DOY, 5'd1, 4'd3, 14'd2024, 16'hFFFF);
		send_request(ACT_TO_DOY, 5'd29, 4'd2, 14'd0, 16'h0000);
		send_request(ACT_TO_DOY, 5'd0, 4'd0, 14'd0, 16'h0000);
		send_request(ACT_TO_DOY, 5'd31, 4'd13, 14'd2000, 16'h0000);
		send_request(ACT_TO_DOY, 5'd31, 4'd15, 14'd16383, 16'hFFFF);
		send_request(ACT_TO_DOY, 5'd15, 4'd7, 14'd9999, 16'h8000);

		// offset to date: day zero, one, short negatives, year edges, extremes
		send_request(ACT_TO_DATE, 5'd31, 4'd15, 14'd2024, 16'd0);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd2024, 16'd1);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd2024, -16'sd1);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd2024, -16'sd31);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd2023, 16'd365);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd2024, 16'd366);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd1900, 16'd60);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd2000, 16'd60);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd9999, 16'h7FFF);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd1, 16'h8000);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd0, 16'h8000);
		send_request(ACT_TO_DATE, 5'd0, 4'd0, 14'd1, -16'sd400);
		send_request(ACT_TO_DATE, 5'd31, 4'd15, 14'd16383, 16'h7FFF);

		// random part, no idling near the end
		for (int i = 0; i < 500; i++) begin
			quiet = (i >= 450);
			send_random();
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
